>>> design/sfu_pkg.sv
// Shared types, constants and step functions for the spotlight cone falloff unit.
// Used by sfu_cos, sfu_cordic, sfu_weight and spotlight_cone_falloff_unit.
package sfu_pkg;

    localparam int COS_FRAC         = 14;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // square root of 2^28 - c*c, one result bit per step
    localparam int SQ_W             = 30;
    localparam int SQ_STEPS         = 15;
    localparam int SQ_PER_STAGE     = 3;
    localparam int SQ_STAGES        = SQ_STEPS / SQ_PER_STAGE;

    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int CORDIC_PRESCALE  = 10;
    localparam int CW               = 27;

    localparam int DIV_BITS         = 16;
    localparam int DIV_PER_STAGE    = 2;
    localparam int DIV_STAGES       = DIV_BITS / DIV_PER_STAGE;

    // pipeline stage counts per unit
    localparam int COS_STAGES       = 3 + SQ_STAGES;
    localparam int ANG_STAGES       = CORDIC_STAGES + 1;
    localparam int WGT_STAGES       = DIV_STAGES + 3;
    localparam int PIPE_STAGES      = COS_STAGES + ANG_STAGES + WGT_STAGES + 1;

    localparam logic signed [CW-1:0] ANGLE_180 = 27'sd11796480;
    localparam logic [16:0]          W_ONE     = 17'd65536;

    // arctangent of 2^-i in degrees, Q8.16
    localparam logic signed [CW-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234378,  27'sd117266,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND     = 3'd0,
        REG_RED      = 3'd1,
        REG_GREEN    = 3'd2,
        REG_BLUE     = 3'd3,
        REG_STRENGTH = 3'd4,
        REG_OUTER    = 3'd5,
        REG_FALLOFF  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_EMISSIVE = 2'd0,
        KIND_SPOT     = 2'd1,
        KIND_NONE     = 2'd2
    } t_kind;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sq;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] q;
    } t_div;

    typedef struct packed {
        logic cut;
        logic full;
    } t_spot_flags;

    function automatic t_sq sq_step(input t_sq a, input int k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] sum;
        t_sq             r;
        bitv = SQ_W'(1) << (2 * k);
        sum  = a.res + bitv;
        if (a.v >= sum) begin
            r.v   = a.v - sum;
            r.res = (a.res >> 1) + bitv;
        end else begin
            r.v   = a.v;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    function automatic t_cordic cordic_step(input t_cordic a, input int i);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        t_cordic              r;
        xs = a.x >>> i;
        ys = a.y >>> i;
        if (a.y > 0) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + ATAN_DEG[i];
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - ATAN_DEG[i];
        end
        return r;
    endfunction

    function automatic t_div div_step(input t_div a, input logic [DIV_BITS-1:0] den);
        logic [DIV_BITS:0] r2;
        t_div              r;
        r2 = {a.rem, 1'b0};
        if (r2 >= {1'b0, den}) begin
            r.rem = DIV_BITS'(r2 - {1'b0, den});
            r.q   = {a.q[DIV_BITS-2:0], 1'b1};
        end else begin
            r.rem = r2[DIV_BITS-1:0];
            r.q   = {a.q[DIV_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> design/sfu_cos.sv
// Cosine front end: dot product, clamp and rounding to Q1.14, then sin by square root.
// Depends on sfu_pkg.
module sfu_cos
    import sfu_pkg::*;
#(
    parameter int VECTOR_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic [COS_STAGES-1:0] i_en,
    input  logic signed [15:0]    i_normal_x,
    input  logic signed [15:0]    i_normal_y,
    input  logic signed [15:0]    i_normal_z,
    input  logic signed [15:0]    i_dir_x,
    input  logic signed [15:0]    i_dir_y,
    input  logic signed [15:0]    i_dir_z,
    output logic [14:0]           o_abs_c,
    output logic                  o_neg,
    output logic [14:0]           o_sin
);

    localparam int DW = (2 * VECTOR_FRAC_BITS + 3 > 35) ? 2 * VECTOR_FRAC_BITS + 3 : 35;
    localparam int SH = 2 * VECTOR_FRAC_BITS - COS_FRAC;
    localparam logic signed [DW-1:0] ONE = {{(DW-1){1'b0}}, 1'b1} << (2 * VECTOR_FRAC_BITS);
    localparam logic [DW-1:0] RND = {{(DW-1){1'b0}}, 1'b1} << (SH - 1);

    logic signed [31:0] r_p0, r_p1, r_p2;
    logic signed [15:0] r_c;
    t_sq                r_sq   [SQ_STAGES+1];
    logic [14:0]        r_abs  [SQ_STAGES+1];
    logic               r_neg  [SQ_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= i_normal_x * i_dir_x;
            r_p1 <= i_normal_y * i_dir_y;
            r_p2 <= i_normal_z * i_dir_z;
        end
    end

    // clamp to [-1, 1], bias, round half up to Q1.14
    logic signed [DW-1:0] n_dot;
    logic signed [DW-1:0] n_clamp;
    logic [DW-1:0]        n_biased;
    logic [DW-1:0]        n_shifted;
    logic [16:0]          n_c;
    always_comb begin
        n_dot = DW'(r_p0) + DW'(r_p1) + DW'(r_p2);
        if (n_dot > ONE) begin
            n_clamp = ONE;
        end else if (n_dot < -ONE) begin
            n_clamp = -ONE;
        end else begin
            n_clamp = n_dot;
        end
        n_biased  = DW'(n_clamp + ONE) + RND;
        n_shifted = n_biased >> SH;
        n_c       = {1'b0, n_shifted[15:0]} - 17'd16384;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_c <= n_c[15:0];
        end
    end

    logic [15:0] n_abs;
    logic [29:0] n_cc;
    always_comb begin
        n_abs = r_c[15] ? 16'(-r_c) : 16'(r_c);
        n_cc  = n_abs[14:0] * n_abs[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sq[0].v   <= (SQ_W'(1) << 28) - n_cc;
            r_sq[0].res <= '0;
            r_abs[0]    <= n_abs[14:0];
            r_neg[0]    <= r_c[15];
        end
    end

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        t_sq n_sq;
        always_comb begin
            n_sq = r_sq[j];
            for (int m = 0; m < SQ_PER_STAGE; m++) begin
                n_sq = sq_step(n_sq, SQ_STEPS - 1 - (j * SQ_PER_STAGE + m));
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[3+j]) begin
                r_sq[j+1]  <= n_sq;
                r_abs[j+1] <= r_abs[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    assign o_abs_c = r_abs[SQ_STAGES];
    assign o_neg   = r_neg[SQ_STAGES];
    assign o_sin   = r_sq[SQ_STAGES].res[14:0];

endmodule

>>> design/sfu_cordic.sv
// Angle unit: vectoring CORDIC over (|cos|, sin), fold for negative cosine, Q8.8 degrees.
// Depends on sfu_pkg.
module sfu_cordic
    import sfu_pkg::*;
(
    input  logic                  i_clk,
    input  logic [ANG_STAGES-1:0] i_en,
    input  logic [14:0]           i_abs_c,
    input  logic                  i_neg,
    input  logic [14:0]           i_sin,
    output logic [15:0]           o_angle
);

    t_cordic     r_cd  [CORDIC_STAGES];
    logic        r_neg [CORDIC_STAGES];
    logic [15:0] r_angle;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
        t_cordic n_cd;
        logic    n_neg;
        always_comb begin
            if (j == 0) begin
                n_cd.x = CW'({i_abs_c, {CORDIC_PRESCALE{1'b0}}});
                n_cd.y = CW'({i_sin, {CORDIC_PRESCALE{1'b0}}});
                n_cd.z = '0;
                n_neg  = i_neg;
            end else begin
                n_cd  = r_cd[(j == 0) ? 0 : j-1];
                n_neg = r_neg[(j == 0) ? 0 : j-1];
            end
            for (int m = 0; m < CORDIC_PER_STAGE; m++) begin
                n_cd = cordic_step(n_cd, j * CORDIC_PER_STAGE + m);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_cd[j]  <= n_cd;
                r_neg[j] <= n_neg;
            end
        end
    end

    // fold, clamp to [0, 180] degrees, round half up to Q8.8
    logic signed [CW-1:0] n_z;
    logic signed [CW-1:0] n_zc;
    logic [CW-1:0]        n_zr;
    always_comb begin
        n_z = r_neg[CORDIC_STAGES-1] ? ANGLE_180 - r_cd[CORDIC_STAGES-1].z
                                     : r_cd[CORDIC_STAGES-1].z;
        if (n_z < 0) begin
            n_zc = '0;
        end else if (n_z > ANGLE_180) begin
            n_zc = ANGLE_180;
        end else begin
            n_zc = n_z;
        end
        n_zr = n_zc + CW'(128);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CORDIC_STAGES]) begin
            r_angle <= n_zr[23:8];
        end
    end

    assign o_angle = r_angle;

endmodule

>>> design/sfu_weight.sv
// Cone weight: cutoff tests, restoring divider for the normalized angle, smoothstep.
// Depends on sfu_pkg.
module sfu_weight
    import sfu_pkg::*;
(
    input  logic                  i_clk,
    input  logic [WGT_STAGES-1:0] i_en,
    input  logic [15:0]           i_angle,
    input  logic [15:0]           i_outer,
    input  logic [15:0]           i_falloff,
    output logic [16:0]           o_weight
);

    logic [15:0]  den;
    t_div         r_dv  [DIV_STAGES+1];
    t_spot_flags  r_fl  [DIV_STAGES+2];
    logic [15:0]  r_f2;
    logic [16:0]  r_w;

    assign den = i_outer - i_falloff;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fl[0].cut  <= (i_angle >= i_outer);
            r_fl[0].full <= (i_angle <= i_falloff);
            r_dv[0].rem  <= i_outer - i_angle;
            r_dv[0].q    <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_div n_dv;
        always_comb begin
            n_dv = r_dv[j];
            for (int m = 0; m < DIV_PER_STAGE; m++) begin
                n_dv = div_step(n_dv, den);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[1+j]) begin
                r_dv[j+1] <= n_dv;
                r_fl[j+1] <= r_fl[j];
            end
        end
    end

    logic [31:0] n_ff;
    assign n_ff = r_dv[DIV_STAGES].q * r_dv[DIV_STAGES].q;

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES+1]) begin
            r_f2               <= n_ff[31:16];
            r_fl[DIV_STAGES+1] <= r_fl[DIV_STAGES];
        end
    end

    // hold f alongside f^2 for the cubic term
    logic [15:0] r_f;
    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES+1]) begin
            r_f <= r_dv[DIV_STAGES].q;
        end
    end

    logic [17:0] n_t;
    logic [33:0] n_p;
    always_comb begin
        n_t = 18'd196608 - 18'({r_f, 1'b0});
        n_p = r_f2 * n_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES+2]) begin
            priority if (r_fl[DIV_STAGES+1].cut) begin
                r_w <= '0;
            end else if (r_fl[DIV_STAGES+1].full) begin
                r_w <= W_ONE;
            end else begin
                r_w <= n_p[32:16];
            end
        end
    end

    assign o_weight = r_w;

endmodule

>>> design/spotlight_cone_falloff_unit.sv
// Top level of the spotlight cone falloff unit: config registers, stage control, output.
// Depends on sfu_pkg, sfu_cos, sfu_cordic and sfu_weight.
//
// Usage: each input transfer on s_axis carries a light normal and a direction from
// the light (six signed Q1.14 components); each output transfer on m_axis carries
// one RGB radiance (three unsigned Q12.12 channels, saturated). One result per item.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, one per cycle;
// indexes past the last register are ignored. The user must write only while no item
// is in flight (not enforced by the block). Stages: 8 for the dot product and square
// root, 9 for the CORDIC angle, 11 for the divider and smoothstep, one output stage
// for the channel multiply. One item enters per cycle while m_axis_tready is high.
// Every stage has its own valid bit and loads when it is empty or its successor moves,
// so bubbles close up and input is still taken while a result waits at the output.
// When the receiver holds m_axis_tready low the output holds and the stages behind it
// fill up; s_axis_tready drops only once all stages are full.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the material kind to
// non-emitting with all other registers zero.
module spotlight_cone_falloff_unit
    import sfu_pkg::*;
#(
    parameter int VECTOR_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32], dir_x[63:48], dir_y[79:64],
    // dir_z[95:80]
    input  logic [95:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // radiance_red[23:0], radiance_green[47:24], radiance_blue[71:48]
    output logic [71:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ANG_BASE = COS_STAGES;
    localparam int WGT_BASE = COS_STAGES + ANG_STAGES;
    localparam int OUT_STG  = PIPE_STAGES - 1;

    logic [1:0]  r_kind;
    logic [15:0] r_red, r_green, r_blue, r_strength, r_outer, r_falloff;
    logic [31:0] r_as_red, r_as_green, r_as_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_NONE;
            r_red      <= '0;
            r_green    <= '0;
            r_blue     <= '0;
            r_strength <= '0;
            r_outer    <= '0;
            r_falloff  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KIND:     r_kind     <= i_cfg_data[1:0];
                REG_RED:      r_red      <= i_cfg_data;
                REG_GREEN:    r_green    <= i_cfg_data;
                REG_BLUE:     r_blue     <= i_cfg_data;
                REG_STRENGTH: r_strength <= i_cfg_data;
                REG_OUTER:    r_outer    <= i_cfg_data;
                REG_FALLOFF:  r_falloff  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // albedo times strength, refreshed from the registers every cycle
    always_ff @(posedge i_clk) begin
        r_as_red   <= r_red * r_strength;
        r_as_green <= r_green * r_strength;
        r_as_blue  <= r_blue * r_strength;
    end

    // stage control: a stage loads when empty or when its successor advances
    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] en;

    assign en[OUT_STG] = !r_valid[OUT_STG] || m_axis_tready;
    for (genvar k = 0; k < OUT_STG; k++) begin : g_en
        assign en[k] = !r_valid[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= (k == 0) ? s_axis_tvalid : r_valid[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_valid[OUT_STG];

    logic [14:0] abs_c;
    logic        neg;
    logic [14:0] sin_v;
    logic [15:0] angle;
    logic [16:0] w_spot;

    sfu_cos #(
        .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS)
    ) u_cos (
        .i_clk      (i_clk),
        .i_en       (en[COS_STAGES-1:0]),
        .i_normal_x (s_axis_tdata[15:0]),
        .i_normal_y (s_axis_tdata[31:16]),
        .i_normal_z (s_axis_tdata[47:32]),
        .i_dir_x    (s_axis_tdata[63:48]),
        .i_dir_y    (s_axis_tdata[79:64]),
        .i_dir_z    (s_axis_tdata[95:80]),
        .o_abs_c    (abs_c),
        .o_neg      (neg),
        .o_sin      (sin_v)
    );

    sfu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (en[ANG_BASE+ANG_STAGES-1:ANG_BASE]),
        .i_abs_c (abs_c),
        .i_neg   (neg),
        .i_sin   (sin_v),
        .o_angle (angle)
    );

    sfu_weight u_weight (
        .i_clk     (i_clk),
        .i_en      (en[WGT_BASE+WGT_STAGES-1:WGT_BASE]),
        .i_angle   (angle),
        .i_outer   (r_outer),
        .i_falloff (r_falloff),
        .o_weight  (w_spot)
    );

    logic [16:0] n_w;
    logic [48:0] n_pr, n_pg, n_pb;
    logic [23:0] r_out_red, r_out_green, r_out_blue;

    always_comb begin
        unique case (r_kind)
            KIND_EMISSIVE: n_w = W_ONE;
            KIND_SPOT:     n_w = w_spot;
            default:       n_w = '0;
        endcase
        n_pr = r_as_red * n_w;
        n_pg = r_as_green * n_w;
        n_pb = r_as_blue * n_w;
    end

    // drop 24 fraction bits, saturate to 24 bits
    always_ff @(posedge i_clk) begin
        if (en[OUT_STG]) begin
            r_out_red   <= n_pr[48] ? 24'hFFFFFF : n_pr[47:24];
            r_out_green <= n_pg[48] ? 24'hFFFFFF : n_pg[47:24];
            r_out_blue  <= n_pb[48] ? 24'hFFFFFF : n_pb[47:24];
        end
    end

    assign m_axis_tdata = {r_out_blue, r_out_green, r_out_red};

endmodule
